// File: rtl/core/chacha20_stream_cipher_unit_macros.svh
// Assertion macros shared by the cipher unit modules.
`ifndef CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/core/cc20_pkg.sv
// Package with types, constants and round helpers for the cipher unit.
`timescale 1ns / 1ps
package cc20_pkg;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int RND_W = 5;
    localparam logic [RND_W-1:0] LAST_HALF = RND_W'(2 * DOUBLE_ROUNDS - 1);
    localparam int QD = 2;
    localparam int QA_W = 1;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;
    localparam logic [2:0] REG_CTR = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out;

    // Front-to-back work entry
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       new_blk;
        logic [5:0] offset;
        logic [31:0] counter;
    } t_job;

    typedef logic [15:0][31:0] t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qr = {ta, tb, tc, td};
    endfunction
endpackage

// File: rtl/core/cc20_front.sv
// Front end: accepts bytes, tracks offset and counter, queues jobs.
`timescale 1ns / 1ps
module cc20_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cc20_pkg::t_in   i_data,
    input  logic [31:0]     i_init_ctr,
    output logic            o_job_valid,
    output cc20_pkg::t_job  o_job,
    input  logic            i_job_pop
);
    import cc20_pkg::*;

    t_job r_q [QD];
    logic [QA_W-1:0] r_wp, r_rp;
    logic [QA_W:0] r_cnt;
    logic [5:0] r_off;
    logic [31:0] r_ctr;
    logic r_start;
    logic push;
    logic [5:0] off_use;
    logic [31:0] ctr_use;

    assign o_stall = (r_cnt == (QA_W+1)'(QD));
    assign push = i_valid && !o_stall;
    assign off_use = r_start ? 6'd0 : r_off;
    assign ctr_use = r_start ? i_init_ctr : r_ctr;
    assign o_job_valid = (r_cnt != '0);
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{data: i_data.data_in, last: i_data.last_byte,
                           new_blk: (off_use == 6'd0), offset: off_use, counter: ctr_use};
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
            r_off <= '0; r_ctr <= '0; r_start <= 1'b1;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
                r_off <= off_use + 6'd1;
                r_ctr <= (off_use == 6'd63) ? ctr_use + 32'd1 : ctr_use;
                r_start <= i_data.last_byte;
            end
            if (i_job_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QA_W+1)'(push) - (QA_W+1)'(i_job_pop);
        end
    end

    `include "chacha20_stream_cipher_unit_macros.svh"
    `CC_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_job_pop, o_job_valid)
    `CC_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (QA_W+1)'(QD))
    `CC_ASSERT_NEXT(a_last_restart, i_clk, i_rst_n, push && i_data.last_byte, r_start)
endmodule

// File: rtl/core/cc20_back.sv
// Back end: block generation with an iterative half-round unit and byte XOR.
`timescale 1ns / 1ps
module cc20_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  cc20_pkg::t_job  i_job,
    output logic            o_job_pop,
    input  logic [255:0]    i_key,
    input  logic [95:0]     i_nonce,
    output logic            o_valid,
    input  logic            i_stall,
    output cc20_pkg::t_out  o_data
);
    import cc20_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_st;

    t_st r_st;
    t_state r_w, r_start, r_ks;
    logic [RND_W-1:0] r_rnd;
    logic r_ov;
    logic r_blk_ok;
    t_out r_out;
    t_state n_w;
    t_state st0;
    logic out_free, take_byte;
    logic [31:0] ks_word;
    logic [7:0] ks_byte;

    always_comb begin
        st0[0] = SIGMA0; st0[1] = SIGMA1; st0[2] = SIGMA2; st0[3] = SIGMA3;
        for (int i = 0; i < 8; i++) st0[4+i] = i_key[32*i +: 32];
        st0[12] = i_job.counter;
        for (int i = 0; i < 3; i++) st0[13+i] = i_nonce[32*i +: 32];
    end

    // One column or diagonal half round per cycle
    always_comb begin
        n_w = r_w;
        for (int q = 0; q < 4; q++) begin
            if (!r_rnd[0]) begin
                {n_w[q], n_w[4+q], n_w[8+q], n_w[12+q]} =
                    qr(r_w[q], r_w[4+q], r_w[8+q], r_w[12+q]);
            end else begin
                {n_w[q], n_w[4+(q+1)%4], n_w[8+(q+2)%4], n_w[12+(q+3)%4]} =
                    qr(r_w[q], r_w[4+(q+1)%4], r_w[8+(q+2)%4], r_w[12+(q+3)%4]);
            end
        end
    end

    assign out_free = !r_ov || !i_stall;
    assign take_byte = (r_st == S_IDLE) && i_job_valid && (!i_job.new_blk || r_blk_ok)
                       && out_free;
    assign o_job_pop = take_byte;
    assign ks_word = r_ks[i_job.offset[5:2]];
    assign ks_byte = ks_word[8*i_job.offset[1:0] +: 8];
    assign o_valid = r_ov;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_rnd <= '0; r_blk_ok <= 1'b0;
        end else begin
            if (take_byte) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_job_valid && i_job.new_blk && !r_blk_ok) begin
                        r_w <= st0; r_start <= st0; r_rnd <= '0; r_st <= S_RUN;
                    end else if (take_byte) begin
                        r_out <= '{data_out: i_job.data ^ ks_byte, last_out: i_job.last};
                        r_blk_ok <= 1'b0;
                    end
                end
                S_RUN: begin
                    r_w <= n_w;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == LAST_HALF) r_st <= S_FIN;
                end
                S_FIN: begin
                    for (int i = 0; i < 16; i++) r_ks[i] <= r_w[i] + r_start[i];
                    // Mark job as a plain byte now that its block exists
                    r_blk_ok <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `include "chacha20_stream_cipher_unit_macros.svh"
    `CC_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_job_pop, r_st == S_IDLE)
    `CC_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_st))
    `CC_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, r_st == S_RUN && r_rnd == LAST_HALF,
                    r_st == S_FIN)
endmodule

// File: rtl/core/chacha20_stream_cipher_unit.sv
// Top level of the ChaCha20 byte stream cipher unit.
`timescale 1ns / 1ps
// Encrypts or decrypts one byte per transfer. The first byte of each 64-byte
// keystream block waits while the block is built by one half-round unit, which
// loads the state, runs 2*DOUBLE_ROUNDS half rounds and adds the input state;
// the other 63 bytes reuse that block. Configuration is sampled when a block
// starts; initial_counter loads at the first byte of each message.
module chacha20_stream_cipher_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cc20_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output cc20_pkg::t_out  o_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data
);
    import cc20_pkg::*;

    logic [255:0] r_key;
    logic [95:0] r_nonce;
    logic [31:0] r_ctr;
    logic job_valid, job_pop;
    t_job job;
    t_job job_fix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0; r_nonce <= '0; r_ctr <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY0: r_key[63:0] <= i_cfg_data;
                REG_KEY1: r_key[127:64] <= i_cfg_data;
                REG_KEY2: r_key[191:128] <= i_cfg_data;
                REG_KEY3: r_key[255:192] <= i_cfg_data;
                REG_NONCE0: r_nonce[63:0] <= i_cfg_data;
                REG_NONCE1: r_nonce[95:64] <= i_cfg_data[31:0];
                REG_CTR: r_ctr <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign job_fix = job;

    cc20_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .i_init_ctr(r_ctr), .o_job_valid(job_valid), .o_job(job),
        .i_job_pop(job_pop)
    );

    cc20_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job_fix),
        .o_job_pop(job_pop), .i_key(r_key), .i_nonce(r_nonce), .o_valid(o_valid),
        .i_stall(i_stall), .o_data(o_data)
    );
endmodule
